// ===== rtl/lldnc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lldnc_pkg: shared widths, codes and types for the neighbor-cost list unit
// Holds the fixed field widths of the request and result channels, the
// operation codes and the saturation limit of the running cost.
// ----------------------------------------------------------------------------
package lldnc_pkg;

    localparam int POS_BITS      = 13;
    localparam int COUNT_BITS    = 13;
    localparam int IN_VALUE_BITS = 10;
    localparam int SUM_BITS      = 11;
    localparam int COST_BITS     = 23;

    typedef logic [COST_BITS-1:0] cost_t;
    typedef logic [POS_BITS-1:0]  pos_t;

    localparam cost_t COST_MAX = '1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DELETE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/linked_list_delete_neighbor_cost_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linked_list_delete_neighbor_cost_unit: array-backed doubly linked list
// with a running cost of deleted entries' neighbor values
// A load request stores a value and links the entry to its plain neighbors;
// a delete request adds its live neighbors' values to a saturating cost and
// unlinks the entry. Each request gives exactly one result.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ----------------------  ---------------------------------
//  cfg       in         cfg_write_en            cfg_write_data (entry_count)
//  in        in         in_valid / in_stall     opcode, position, item_value
//  out       out        out_valid / out_stall   neighbor_sum, total_cost,
//                                               bad_request
//
//  A load or an out-of-range request is handled on acceptance. A delete steps
//  through entry read, neighbor reads with the entry write, left write and
//  right write (an entry already removed skips the neighbor and left steps),
//  since the entry RAM has a single write port.
//  Reset clears the cost, sets entry_count to 1 and empties the output register.
//  A stalled result stays in the output register and holds off new requests.
//
module linked_list_delete_neighbor_cost_unit #(
    parameter int MAX_ENTRIES = 4096,
    parameter int VALUE_BITS  = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_write_en,
    input  logic [lldnc_pkg::COUNT_BITS-1:0]     cfg_write_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [lldnc_pkg::POS_BITS-1:0]       position,
    input  logic [lldnc_pkg::IN_VALUE_BITS-1:0]  item_value,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lldnc_pkg::SUM_BITS-1:0]       neighbor_sum,
    output logic [lldnc_pkg::COST_BITS-1:0]      total_cost,
    output logic                                 bad_request
);

    // RAM address width (entries are addressed directly by position, entry 0
    // is unused), link width (a link can point one past the last entry) and
    // the common width used for range compares.
    localparam int AW   = $clog2(MAX_ENTRIES + 1);
    localparam int LW   = $clog2(MAX_ENTRIES + 2);
    localparam int CW   = (LW > lldnc_pkg::POS_BITS) ? LW : lldnc_pkg::POS_BITS;
    localparam int SW   = VALUE_BITS + 1;
    localparam int ADDW = ((lldnc_pkg::COST_BITS > SW) ? lldnc_pkg::COST_BITS : SW) + 1;
    localparam int WW   = 1 + VALUE_BITS + 2 * LW;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ENTRY = 2'd1;
    localparam logic [1:0] S_NBR   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // One RAM word holds everything known about an entry.
    typedef struct packed {
        logic                  removed;
        logic [VALUE_BITS-1:0] value;
        logic [LW-1:0]         right;
        logic [LW-1:0]         left;
    } entry_t;

    logic [1:0]                         state_reg, state_next;
    logic [lldnc_pkg::COUNT_BITS-1:0]   entry_count_reg, entry_count_next;
    lldnc_pkg::cost_t                   cost_reg, cost_next;
    logic [AW-1:0]                      pos_reg, pos_next;
    logic [LW-1:0]                      l_reg, l_next;
    logic [LW-1:0]                      r_reg, r_next;
    logic                               has_l_reg, has_l_next;
    logic                               has_r_reg, has_r_next;
    logic                               wr_r_reg, wr_r_next;
    entry_t                             base_r_reg, base_r_next;
    logic [lldnc_pkg::SUM_BITS-1:0]     res_sum_reg, res_sum_next;
    logic                               res_bad_reg, res_bad_next;

    logic                               out_valid_reg, out_valid_next;
    logic [lldnc_pkg::SUM_BITS-1:0]     out_sum_reg, out_sum_next;
    lldnc_pkg::cost_t                   out_cost_reg, out_cost_next;
    logic                               out_bad_reg, out_bad_next;

    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    entry_t                             mem_wdata;
    logic [AW-1:0]                      rd_addr_a;
    logic [AW-1:0]                      rd_addr_b;
    logic [WW-1:0]                      rd_data_a;
    logic [WW-1:0]                      rd_data_b;
    entry_t                             word_a;
    entry_t                             word_b;
    entry_t                             l_mod;

    logic                               out_free;
    logic                               acc;
    logic [CW-1:0]                      n_eff;
    logic [CW-1:0]                      pos_c;
    logic                               pos_ok;
    logic                               has_l_c;
    logic                               has_r_c;
    logic [SW-1:0]                      sum_c;
    logic [ADDW-1:0]                    cost_wide;

    // Entry store: one word per entry, read at up to two addresses a cycle.
    lldnc_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_ENTRIES + 1)
    ) u_entry_ram (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign word_a = entry_t'(rd_data_a);
    assign word_b = entry_t'(rd_data_b);

    // The output register can take a result when it is empty or drains now.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign acc      = in_valid && !in_stall;

    // An entry_count beyond the RAM acts as the RAM size.
    assign n_eff = (CW'(entry_count_reg) > CW'(MAX_ENTRIES)) ?
                   CW'(MAX_ENTRIES) : CW'(entry_count_reg);

    assign pos_c  = CW'(position);
    assign pos_ok = (pos_c != '0) && (pos_c <= n_eff);

    // Links of the entry being deleted, valid in the entry read cycle. A link
    // outside the live range is a missing side and is never followed.
    assign has_l_c = (CW'(word_a.left) != '0)  && (CW'(word_a.left) <= n_eff);
    assign has_r_c = (CW'(word_a.right) != '0) && (CW'(word_a.right) <= n_eff);

    // Neighbor sum and saturating cost, valid in the neighbor read cycle.
    assign sum_c = (has_l_reg ? SW'(word_a.value) : '0) +
                   (has_r_reg ? SW'(word_b.value) : '0);
    assign cost_wide = ADDW'(cost_reg) + ADDW'(sum_c);

    always_comb
    begin
        l_mod       = word_a;
        l_mod.right = r_reg;
    end

    // Read address selection.
    always_comb
    begin
        rd_addr_a = pos_c[AW-1:0];
        rd_addr_b = pos_reg;
        if (state_reg == S_ENTRY)
        begin
            rd_addr_a = has_l_c ? word_a.left[AW-1:0]  : pos_reg;
            rd_addr_b = has_r_c ? word_a.right[AW-1:0] : pos_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        cost_next        = cost_reg;
        pos_next         = pos_reg;
        l_next           = l_reg;
        r_next           = r_reg;
        has_l_next       = has_l_reg;
        has_r_next       = has_r_reg;
        wr_r_next        = wr_r_reg;
        base_r_next      = base_r_reg;
        res_sum_next     = res_sum_reg;
        res_bad_next     = res_bad_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_sum_next     = out_sum_reg;
        out_cost_next    = out_cost_reg;
        out_bad_next     = out_bad_reg;
        mem_we           = 1'b0;
        mem_waddr        = pos_reg;
        mem_wdata        = base_r_reg;

        if (cfg_write_en)
        begin
            entry_count_next = cfg_write_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!pos_ok)
                    begin
                        // Rejected position: nothing changes.
                        out_valid_next = 1'b1;
                        out_sum_next   = '0;
                        out_cost_next  = cost_reg;
                        out_bad_next   = 1'b1;
                    end
                    else if (opcode == lldnc_pkg::OP_LOAD)
                    begin
                        // A load links the entry to its plain neighbors.
                        mem_we          = 1'b1;
                        mem_waddr       = pos_c[AW-1:0];
                        mem_wdata.removed = 1'b0;
                        mem_wdata.value = VALUE_BITS'(item_value);
                        mem_wdata.left  = LW'(pos_c - CW'(1));
                        mem_wdata.right = LW'(pos_c + CW'(1));
                        if (position == lldnc_pkg::POS_BITS'(1))
                        begin
                            cost_next = '0;
                        end
                        out_valid_next = 1'b1;
                        out_sum_next   = '0;
                        out_cost_next  = (position == lldnc_pkg::POS_BITS'(1)) ?
                                         '0 : cost_reg;
                        out_bad_next   = 1'b0;
                    end
                    else
                    begin
                        // Delete: the entry read has been issued this cycle.
                        pos_next   = pos_c[AW-1:0];
                        state_next = S_ENTRY;
                    end
                end
            end

            S_ENTRY:
            begin
                if (word_a.removed)
                begin
                    res_sum_next = '0;
                    res_bad_next = 1'b1;
                    wr_r_next    = 1'b0;
                    state_next   = S_FIN;
                end
                else
                begin
                    // Retire the entry now; neighbor reads see the old word.
                    mem_we            = 1'b1;
                    mem_waddr         = pos_reg;
                    mem_wdata.removed = 1'b1;
                    mem_wdata.value   = word_a.value;
                    mem_wdata.left    = '0;
                    mem_wdata.right   = '0;
                    l_next            = word_a.left;
                    r_next            = word_a.right;
                    has_l_next        = has_l_c;
                    has_r_next        = has_r_c;
                    state_next        = S_NBR;
                end
            end

            S_NBR:
            begin
                cost_next = (cost_wide > ADDW'(lldnc_pkg::COST_MAX)) ?
                            lldnc_pkg::COST_MAX : cost_wide[lldnc_pkg::COST_BITS-1:0];
                res_sum_next = lldnc_pkg::SUM_BITS'(sum_c);
                res_bad_next = 1'b0;

                // A neighbor that is the deleted entry itself keeps the
                // retired word written in the previous cycle.
                if (has_l_reg && (l_reg != LW'(pos_reg)))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = l_reg[AW-1:0];
                    mem_wdata = l_mod;
                end

                // When both links name the same entry, the right-side update
                // builds on the left-side one.
                base_r_next      = (has_l_reg && (r_reg == l_reg)) ? l_mod : word_b;
                base_r_next.left = l_reg;
                wr_r_next        = has_r_reg && (r_reg != LW'(pos_reg));
                state_next       = S_FIN;
            end

            S_FIN:
            begin
                // Rewriting the same word while the output is stalled is
                // harmless.
                if (wr_r_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = r_reg[AW-1:0];
                    mem_wdata = base_r_reg;
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = res_sum_reg;
                    out_cost_next  = cost_reg;
                    out_bad_next   = res_bad_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= lldnc_pkg::COUNT_BITS'(1);
            cost_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            cost_reg        <= cost_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        has_l_reg   <= has_l_next;
        has_r_reg   <= has_r_next;
        wr_r_reg    <= wr_r_next;
        base_r_reg  <= base_r_next;
        res_sum_reg <= res_sum_next;
        res_bad_reg <= res_bad_next;
        out_sum_reg <= out_sum_next;
        out_cost_reg <= out_cost_next;
        out_bad_reg <= out_bad_next;
    end

    assign out_valid    = out_valid_reg;
    assign neighbor_sum = out_sum_reg;
    assign total_cost   = out_cost_reg;
    assign bad_request  = out_bad_reg;

`ifndef SYNTHESIS
    // The running cost only falls when a load at position 1 is accepted.
    a_cost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (cost_reg < $past(cost_reg)) |->
        $past(acc && (opcode == lldnc_pkg::OP_LOAD) &&
              (position == lldnc_pkg::POS_BITS'(1))))
        else $error("running cost fell without a load at position 1");

    // The RAM is written only by an accepted load or by a delete in progress.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg != S_IDLE) ||
                    (acc && (opcode == lldnc_pkg::OP_LOAD))))
        else $error("entry RAM written outside a request");

    // A rejected request never reports a neighbor sum.
    a_bad_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_sum_reg == '0))
        else $error("rejected request carries a neighbor sum");

    // A finished delete hands its result over and frees the sequencer.
    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && out_free) |=>
        ((state_reg == S_IDLE) && out_valid_reg))
        else $error("finished delete did not deliver its result");
`endif

endmodule

`default_nettype wire

// ===== rtl/lldnc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lldnc_ram: generic RAM with one write port and two registered read ports
// A read returns the contents from before a write to the same address in the
// same cycle.
// ----------------------------------------------------------------------------
module lldnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

`default_nettype wire

// ===== test/linked_list_delete_neighbor_cost_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_delete_neighbor_cost_unit_test: self-checking bench for the unit
// Sends load and delete requests under random idling and stalls. A model of
// the list predicts each result that a directed row does not give, and each
// result is checked field by field. Phases change entry_count between them.
// ----------------------------------------------------------------------------
module linked_list_delete_neighbor_cost_unit_test;

    localparam int DEPTH            = 4096;
    // Together with the directed requests this gives about 900 requests.
    localparam int RANDOM_ITEMS     = 875;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 20;
    localparam int HOLD_CYCLES      = 200;
    localparam int HOLD_EVERY       = 350;
    localparam int CYCLE_LIMIT      = 4000000;
    localparam int REPORT_LIMIT     = 10;

    typedef logic [lldnc_pkg::IN_VALUE_BITS-1:0] value_t;
    typedef logic [lldnc_pkg::COUNT_BITS-1:0]    count_t;

    typedef struct packed {
        logic [lldnc_pkg::SUM_BITS-1:0] sum;
        lldnc_pkg::cost_t               cost;
        logic                           bad;
    } list_result_t;

    // A row of the directed table is a request or a write of entry_count.
    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e    kind;
        logic         op;
        int unsigned  pos;      // holds the new entry_count on a config row
        int unsigned  val;
        bit           typed;    // the expected result is the one written in the row
        list_result_t result;
    } stim_row_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_write_en;
    count_t cfg_write_data;
    logic   in_valid;
    logic   in_stall;
    logic   opcode;
    lldnc_pkg::pos_t position;
    value_t item_value;
    logic   out_valid;
    logic   out_stall;
    logic [lldnc_pkg::SUM_BITS-1:0] neighbor_sum;
    lldnc_pkg::cost_t total_cost;
    logic   bad_request;

    // Shadow copy of the list. was_loaded tracks which entries have been
    // written, since the unit's RAM holds garbage until then.
    lldnc_pkg::pos_t prev_link    [0:DEPTH];
    lldnc_pkg::pos_t next_link    [0:DEPTH];
    value_t          stored_value [0:DEPTH];
    bit              is_removed   [0:DEPTH];
    bit              was_loaded   [0:DEPTH];
    lldnc_pkg::cost_t model_cost;
    count_t           model_count;

    list_result_t pending_results[$];
    stim_row_t    directed_rows[$];
    int unsigned  accepted_count;
    int unsigned  mismatch_count;
    int unsigned  result_count;
    int unsigned  cycle_count;
    bit           quiet_phase;

    linked_list_delete_neighbor_cost_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .position       (position),
        .item_value     (item_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .neighbor_sum   (neighbor_sum),
        .total_cost     (total_cost),
        .bad_request    (bad_request)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------

    // entry_count above the array size acts as the array size.
    function automatic int live_entries();
        return (model_count > DEPTH) ? DEPTH : int'(model_count);
    endfunction

    function automatic bit in_list(int unsigned k);
        return (k >= 1) && (k <= live_entries());
    endfunction

    // Applies one request to the shadow list and returns the result that the
    // unit must give for it.
    function automatic list_result_t apply_list_request(logic op, lldnc_pkg::pos_t pos,
                                                        value_t val);
        list_result_t res;
        int unsigned  left;
        int unsigned  right;
        int unsigned  added;
        bit           has_left;
        bit           has_right;
        res   = '0;
        added = 0;
        if (!in_list(pos))
        begin
            res.bad = 1'b1;
        end
        else if (op == lldnc_pkg::OP_LOAD)
        begin
            stored_value[pos] = val;
            prev_link[pos]    = pos - 1'b1;
            next_link[pos]    = pos + 1'b1;
            is_removed[pos]   = 1'b0;
            was_loaded[pos]   = 1'b1;
            // Loading the first entry starts a new row, so the cost restarts.
            if (pos == 1)
                model_cost = '0;
        end
        else if (is_removed[pos])
        begin
            res.bad = 1'b1;
        end
        else
        begin
            left      = prev_link[pos];
            right     = next_link[pos];
            has_left  = in_list(left);
            has_right = in_list(right);
            if (has_left)
                added += stored_value[left];
            if (has_right)
                added += stored_value[right];
            if (longint'(model_cost) + added > longint'(lldnc_pkg::COST_MAX))
                model_cost = lldnc_pkg::COST_MAX;
            else
                model_cost = model_cost + lldnc_pkg::cost_t'(added);
            // Splice the neighbors together; a side outside the list is left alone.
            if (has_left)
                next_link[left] = lldnc_pkg::pos_t'(right);
            if (has_right)
                prev_link[right] = lldnc_pkg::pos_t'(left);
            prev_link[pos]  = '0;
            next_link[pos]  = '0;
            is_removed[pos] = 1'b1;
        end
        res.sum  = added[lldnc_pkg::SUM_BITS-1:0];
        res.cost = model_cost;
        return res;
    endfunction

    // A delete is only sent when it touches written entries alone: the entry
    // itself and any neighbor that its links reach inside the list.
    function automatic bit delete_is_defined(int unsigned pos);
        if (!in_list(pos))
            return 1'b1;
        if (!was_loaded[pos])
            return 1'b0;
        if (is_removed[pos])
            return 1'b1;
        if (in_list(prev_link[pos]) && !was_loaded[prev_link[pos]])
            return 1'b0;
        if (in_list(next_link[pos]) && !was_loaded[next_link[pos]])
            return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Mostly short gaps, some medium, a few long ones; none in a quiet phase.
    function automatic int pick_gap();
        int unsigned roll;
        if (quiet_phase)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one request and holds it until the unit takes it. The expected
    // result is worked out at acceptance, so the model sees requests in the
    // same order as the unit does. Valid stays high after acceptance so that
    // back-to-back requests never lower and raise it in one time step.
    task automatic send_request(input logic op, input int unsigned pos,
                                input int unsigned val, input bit typed,
                                input list_result_t typed_result);
        list_result_t predicted;
        int           gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        position   <= lldnc_pkg::pos_t'(pos);
        item_value <= value_t'(val);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_list_request(op, lldnc_pkg::pos_t'(pos), value_t'(val));
        pending_results = {pending_results, (typed ? typed_result : predicted)};
        accepted_count++;
    endtask

    // entry_count is only written with the unit empty: every result is in and
    // the pipeline has been given time to settle.
    task automatic set_entry_count(input int unsigned count);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= count_t'(count);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        model_count = count_t'(count);
    endtask

    function automatic stim_row_t mk_row(row_kind_e kind, logic op, int unsigned pos,
                                         int unsigned val, bit typed, int unsigned sum,
                                         int unsigned cost, bit bad);
        stim_row_t row;
        row.kind        = kind;
        row.op          = op;
        row.pos         = pos;
        row.val         = val;
        row.typed       = typed;
        row.result.sum  = sum[lldnc_pkg::SUM_BITS-1:0];
        row.result.cost = lldnc_pkg::cost_t'(cost);
        row.result.bad  = bad;
        return row;
    endfunction

    function automatic void add_row(stim_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    initial
    begin : stimulus
        int unsigned lo;
        int unsigned hi;
        int unsigned width;
        int unsigned n_eff;
        int unsigned ops;
        int unsigned step;
        int unsigned roll;
        int unsigned pos;
        int unsigned count;
        int unsigned random_items;
        logic        op;

        in_valid       = 1'b0;
        opcode         = lldnc_pkg::OP_LOAD;
        position       = '0;
        item_value     = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        rst_n          = 1'b0;
        quiet_phase    = 1'b0;
        model_cost     = '0;
        model_count    = count_t'(1);

        // Reset leaves a single entry in use and a cost of zero, so the first
        // rows can carry their results written out.
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 0,    0,    1'b1, 0, 0, 1'b1));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   2,    0,    1'b1, 0, 0, 1'b1));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 8191, 0,    1'b1, 0, 0, 1'b1));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   1,    1023, 1'b1, 0, 0, 1'b0));
        // Alone in the list: both sides are missing and nothing is added.
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 1,    0,    1'b1, 0, 0, 1'b0));
        // Deleting an entry that is already gone is rejected.
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 1,    0,    1'b1, 0, 0, 1'b1));
        // A load brings a removed entry back.
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   1,    0,    1'b1, 0, 0, 1'b0));
        add_row(mk_row(ROW_CFG, lldnc_pkg::OP_LOAD,   6,    0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   1,    1023, 1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   2,    1023, 1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   3,    0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   4,    1023, 1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   5,    512,  1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   6,    341,  1'b0, 0, 0, 1'b0));
        // After entry 2 goes, entry 3 sees 1 and 4, both full scale: the
        // largest neighbor sum. Entry 1 then has only a right side, and the
        // last entry only a left side.
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 2,    0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 3,    0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 1,    0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 6,    0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 3,    0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   7,    9,    1'b0, 0, 0, 1'b0));
        // A count past the array size is clipped to it.
        add_row(mk_row(ROW_CFG, lldnc_pkg::OP_LOAD,   8191, 0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   4096, 1023, 1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   4095, 5,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 4096, 0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   4097, 7,    1'b0, 0, 0, 1'b0));
        // With no entries in use every position is rejected.
        add_row(mk_row(ROW_CFG, lldnc_pkg::OP_LOAD,   0,    0,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_LOAD,   1,    7,    1'b0, 0, 0, 1'b0));
        add_row(mk_row(ROW_REQ, lldnc_pkg::OP_DELETE, 1,    0,    1'b0, 0, 0, 1'b0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                set_entry_count(directed_rows[i].pos);
            else
                send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                             directed_rows[i].typed, directed_rows[i].result);
        end

        // Random phases. Each picks an entry_count, fills a window of entries
        // so that deletes have real neighbors, then mixes deletes and reloads
        // around that window with some requests at arbitrary positions.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 9);
            case (roll)
                0:       count = 1;
                1:       count = 2;
                2:       count = DEPTH;
                3:       count = $urandom_range(DEPTH + 1, 8191);
                4:       count = 0;
                default: count = $urandom_range(3, 48);
            endcase
            set_entry_count(count);
            quiet_phase = ($urandom_range(0, 3) == 0);
            n_eff = live_entries();
            if (n_eff > 0)
            begin
                width = $urandom_range(2, 40);
                if (width > n_eff)
                    width = n_eff;
                lo = $urandom_range(1, n_eff - width + 1);
                hi = lo + width - 1;
                for (pos = lo; (pos <= hi) && (random_items < RANDOM_ITEMS); pos++)
                begin
                    send_request(lldnc_pkg::OP_LOAD, pos, $urandom_range(0, 1023), 1'b0, '0);
                    random_items++;
                end
                ops = $urandom_range(40, 120);
            end
            else
            begin
                lo  = 1;
                hi  = 1;
                ops = 12;
            end
            for (step = 0; (step < ops) && (random_items < RANDOM_ITEMS); step++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 85)
                begin
                    op  = (roll < 60) ? lldnc_pkg::OP_DELETE : lldnc_pkg::OP_LOAD;
                    pos = $urandom_range(lo - 1, hi + 1);
                end
                else
                begin
                    op  = ($urandom_range(0, 1) == 0) ? lldnc_pkg::OP_LOAD
                                                      : lldnc_pkg::OP_DELETE;
                    pos = $urandom_range(0, 8191);
                end
                // A delete that would read an unwritten entry turns into a
                // load of that entry, which makes it defined from then on.
                if (op == lldnc_pkg::OP_DELETE && !delete_is_defined(pos))
                    op = lldnc_pkg::OP_LOAD;
                send_request(op, pos, $urandom_range(0, 1023), 1'b0, '0);
                random_items++;
            end
        end
        quiet_phase = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Any stray result that shows up late is caught by the checker here.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Random stall pattern on the result channel. Every HOLD_EVERY accepted
    // requests the receiver stops taking results for a long stretch while
    // the sender keeps offering, so the output register fills and the unit
    // has to push back on its input.
    initial
    begin : receiver
        logic        level;
        int unsigned span;
        int unsigned roll;
        int unsigned next_hold_at;
        next_hold_at = HOLD_EVERY;
        forever
        begin
            roll = $urandom_range(0, 99);
            if (accepted_count >= next_hold_at)
            begin
                next_hold_at = accepted_count + HOLD_EVERY;
                level = 1'b1;
                span  = HOLD_CYCLES;
            end
            else if (quiet_phase || roll < 70)
            begin
                level = 1'b0;
                span  = quiet_phase ? 1 : $urandom_range(1, 6);
            end
            else if (roll < 95)
            begin
                level = 1'b1;
                span  = $urandom_range(1, 3);
            end
            else
            begin
                level = 1'b1;
                span  = $urandom_range(10, 40);
            end
            out_stall <= level;
            repeat (span) @(negedge clk);
        end
    end

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] result %0d: %s", $realtime, result_count, what);
    endtask

    // Every result the unit hands over is matched against the oldest
    // prediction still waiting.
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.sum  = neighbor_sum;
            got.cost = total_cost;
            got.bad  = bad_request;
            if (pending_results.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result sum=%0d cost=%0d bad=%0d",
                                       got.sum, got.cost, got.bad));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.sum !== want.sum || got.cost !== want.cost || got.bad !== want.bad)
                    log_mismatch($sformatf(
                        "expected sum=%0d cost=%0d bad=%0d, got sum=%0d cost=%0d bad=%0d",
                        want.sum, want.cost, want.bad, got.sum, got.cost, got.bad));
            end
            result_count++;
        end
    end

    // Hard stop in case the unit hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
